// File: rtl/core/bfr_pkg.sv
`timescale 1ns / 1ps

package bfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned OUT_LEN_W  = 6;

  // frame layout: header, command, length, payload..., checksum, tail
  localparam int unsigned CMD_POS        = 1;
  localparam int unsigned LENGTH_POS     = 2;
  localparam int unsigned PAYLOAD_START  = 3;
  localparam int unsigned FRAME_OVERHEAD = 5;

  // position arithmetic width: length (8b) + overhead, no wrap
  localparam int unsigned POS_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RST   = 8'h55;

  // handoff from receiver to emitter when a frame checks out
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] plen;
  } frame_info_t;

endpackage

// File: rtl/core/bfr_ram.sv
`timescale 1ns / 1ps

module bfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bfr_rx.sv
`timescale 1ns / 1ps

module bfr_rx #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         byte_acc,
  input  logic [bfr_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [bfr_pkg::BYTE_W-1:0]   header_byte,
  input  logic [bfr_pkg::BYTE_W-1:0]   tail_byte,
  output logic                         ram_we,
  output logic [$clog2(STORE_BYTES)-1:0] ram_waddr,
  output logic [bfr_pkg::BYTE_W-1:0]   ram_wdata,
  output bfr_pkg::frame_info_t         info
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned IW = $clog2(STORE_BYTES + 1);
  localparam int unsigned PW = bfr_pkg::POS_W;
  localparam int unsigned BW = bfr_pkg::BYTE_W;

  logic          in_frame_r, in_frame_nxt;
  logic [IW-1:0] wi_r, wi_nxt;
  logic [BW-1:0] cmd_r, cmd_nxt;
  logic [BW-1:0] len_r, len_nxt;
  logic [BW-1:0] sum_r, sum_nxt;
  logic          ck_ok_r, ck_ok_nxt;

  logic [PW-1:0] pos;
  logic [PW-1:0] ck_pos;
  logic [PW-1:0] tail_pos;
  logic          full;
  logic          start;

  assign pos      = PW'(wi_r);
  assign ck_pos   = PW'(len_r) + PW'(bfr_pkg::PAYLOAD_START);
  assign tail_pos = ck_pos + PW'(1);
  assign full     = (wi_r >= IW'(STORE_BYTES));

  always_comb begin
    in_frame_nxt = in_frame_r;
    wi_nxt       = wi_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    ck_ok_nxt    = ck_ok_r;
    ram_we       = 1'b0;
    start        = 1'b0;
    if (byte_acc) begin
      if (!in_frame_r) begin
        if (rx_byte == header_byte) begin
          ram_we       = 1'b1;
          wi_nxt       = IW'(1);
          in_frame_nxt = 1'b1;
        end
      end else if (full) begin
        // overflow: frame abandoned, this byte dropped
        in_frame_nxt = 1'b0;
      end else begin
        ram_we = 1'b1;
        wi_nxt = wi_r + IW'(1);
        if (pos == PW'(bfr_pkg::CMD_POS)) begin
          cmd_nxt = rx_byte;
        end else if (pos == PW'(bfr_pkg::LENGTH_POS)) begin
          len_nxt = rx_byte;
          sum_nxt = '0;
        end else if (pos < ck_pos) begin
          sum_nxt = sum_r + rx_byte;
        end else if (pos == ck_pos) begin
          ck_ok_nxt = (rx_byte == sum_r);
        end else if (pos == tail_pos) begin
          in_frame_nxt = 1'b0;
          start        = ck_ok_r && (rx_byte == tail_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      wi_r       <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      wi_r       <= wi_nxt;
    end
    cmd_r   <= cmd_nxt;
    len_r   <= len_nxt;
    sum_r   <= sum_nxt;
    ck_ok_r <= ck_ok_nxt;
  end

  // header lands at 0; otherwise wi_r < STORE_BYTES whenever we write
  assign ram_waddr  = in_frame_r ? wi_r[AW-1:0] : '0;
  assign ram_wdata  = rx_byte;
  assign info.start = start;
  assign info.cmd   = cmd_r;
  assign info.plen  = len_r;

endmodule

// File: rtl/core/bfr_emit.sv
`timescale 1ns / 1ps

module bfr_emit #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bfr_pkg::frame_info_t           info,
  output logic                           busy,
  output logic [$clog2(STORE_BYTES)-1:0] ram_raddr,
  input  logic [bfr_pkg::BYTE_W-1:0]     ram_rdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bfr_pkg::BYTE_W-1:0]     out_command,
  output logic [bfr_pkg::OUT_LEN_W-1:0]  out_payload_length,
  output logic [bfr_pkg::OUT_LEN_W-1:0]  out_byte_index,
  output logic [bfr_pkg::BYTE_W-1:0]     out_data,
  output logic                           out_last
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned BW = bfr_pkg::BYTE_W;
  localparam int unsigned LW = bfr_pkg::OUT_LEN_W;
  localparam int unsigned CW = BW + 1;

  localparam logic [1:0] EM_IDLE = 2'd0;
  localparam logic [1:0] EM_RD   = 2'd1;
  localparam logic [1:0] EM_LD   = 2'd2;
  localparam logic [1:0] EM_HOLD = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [BW-1:0] cmd_r, cmd_nxt;
  logic [BW-1:0] plen_r, plen_nxt;
  logic [BW-1:0] data_r, data_nxt;
  logic [LW-1:0] len_o_r, len_o_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd_nxt   = cmd_r;
    plen_nxt  = plen_r;
    data_nxt  = data_r;
    len_o_nxt = len_o_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    unique case (state_r)
      EM_IDLE: begin
        if (info.start) begin
          cmd_nxt   = info.cmd;
          plen_nxt  = info.plen;
          len_o_nxt = info.plen[LW-1:0];
          k_nxt     = '0;
          if (info.plen == '0) begin
            // empty payload: single marker beat
            data_nxt  = '0;
            idx_nxt   = '0;
            last_nxt  = 1'b1;
            state_nxt = EM_HOLD;
          end else begin
            state_nxt = EM_RD;
          end
        end
      end
      EM_RD: begin
        state_nxt = EM_LD;
      end
      EM_LD: begin
        data_nxt  = ram_rdata;
        idx_nxt   = LW'(k_r);
        last_nxt  = (CW'(k_r) + CW'(1)) == CW'(plen_r);
        state_nxt = EM_HOLD;
      end
      EM_HOLD: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = EM_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = EM_RD;
          end
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r     <= k_nxt;
    cmd_r   <= cmd_nxt;
    plen_r  <= plen_nxt;
    data_r  <= data_nxt;
    len_o_r <= len_o_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
  end

  assign ram_raddr          = AW'(bfr_pkg::PAYLOAD_START) + k_r;
  assign busy               = (state_r != EM_IDLE);
  assign out_valid          = (state_r == EM_HOLD);
  assign out_command        = cmd_r;
  assign out_payload_length = len_o_r;
  assign out_byte_index     = idx_r;
  assign out_data           = data_r;
  assign out_last           = last_r;

endmodule

// File: rtl/core/byte_frame_receiver_core.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_byte[7:0]
// out     | output    | out_valid / out_ready | out_command, out_payload_length,
//         |           |                       | out_byte_index, out_data, out_last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index[7:0], cfg_data[7:0]
//
// Receive: one byte beat per cycle while in_ready is high; hunt, store write, running
// sum and compares on arrival. Emit: a good frame stalls the input; each result beat
// steps through a registered frame store read, output load and hold, the hold lasting
// until out_ready. An empty payload gives its single beat in the cycle after the tail.
// Reset: synchronous active low; clears framing and emit state, loads
// header 0xAA and tail 0x55. Frame store has no reset. cfg_ready is always 1.

module byte_frame_receiver_core #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_command,
  output logic [5:0]  out_payload_length,
  output logic [5:0]  out_byte_index,
  output logic [7:0]  out_data,
  output logic        out_last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned BW = bfr_pkg::BYTE_W;

  logic [BW-1:0] header_r, header_nxt;
  logic [BW-1:0] tail_r, tail_nxt;

  logic                 emit_busy;
  logic                 byte_acc;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [BW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [BW-1:0]        ram_rdata;
  bfr_pkg::frame_info_t info;

  // config registers; writes to unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    header_nxt = header_r;
    tail_nxt   = tail_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bfr_pkg::REG_HEADER: header_nxt = cfg_data;
        bfr_pkg::REG_TAIL:   tail_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= bfr_pkg::HEADER_RST;
      tail_r   <= bfr_pkg::TAIL_RST;
    end else begin
      header_r <= header_nxt;
      tail_r   <= tail_nxt;
    end
  end

  // input held off while a frame's payload is being sent
  assign in_ready = !emit_busy;
  assign byte_acc = in_valid && in_ready;

  bfr_rx #(
    .STORE_BYTES(STORE_BYTES)
  ) u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .rx_byte    (in_byte),
    .header_byte(header_r),
    .tail_byte  (tail_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .info       (info)
  );

  bfr_ram #(
    .WIDTH(BW),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bfr_emit #(
    .STORE_BYTES(STORE_BYTES)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .info              (info),
    .busy              (emit_busy),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_payload_length(out_payload_length),
    .out_byte_index    (out_byte_index),
    .out_data          (out_data),
    .out_last          (out_last)
  );

endmodule

// File: verif/byte_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module byte_frame_receiver_core_tb;
  import bfr_pkg::*;

  localparam int unsigned STORE_BYTES = 64;
  localparam int unsigned SETTLE_CYCLES = 12;  // emitter steps through read, load and hold per beat
  localparam int unsigned HOLD_CYCLES = 300;   // long out_ready hold-off
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  // index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(8'h7F);

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_TAIL} frame_flaw_t;

  // one deframed payload beat as the out channel carries it
  typedef struct {
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [5:0] byte_index;
    logic [7:0] data;
    logic       last;
  } payload_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;

  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_command;
  logic [5:0] out_payload_length;
  logic [5:0] out_byte_index;
  logic [7:0] out_data;
  logic       out_last;

  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  // deframer shadow: store, fill count, framing flag and registers
  logic [7:0]  shadow_store [STORE_BYTES];
  int unsigned shadow_fill;
  bit          shadow_open;
  logic [7:0]  hdr_val;
  logic [7:0]  tail_val;

  payload_beat_t expected_beats [$];

  int errors = 0;
  int beats_seen = 0;
  int beats_predicted = 0;
  int tx_count = 0;

  // traffic shaping knobs
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_on = 1'b0;

  byte_frame_receiver_core #(
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_payload_length(out_payload_length),
    .out_byte_index    (out_byte_index),
    .out_data          (out_data),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #2 clk = ~clk;

  // Deframer prediction for one accepted in beat. Pushes the payload beats
  // of a frame that completes here with good tail and sum.
  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned plen;
    int unsigned total;
    logic [7:0] sum;
    payload_beat_t pb;
    // hunting: only the header opens a frame
    if (!shadow_open) begin
      if (b == hdr_val) begin
        shadow_store[0] = b;
        shadow_fill = 1;
        shadow_open = 1'b1;
      end
      return;
    end
    // store full: this byte closes the frame and is dropped, not a header
    if (shadow_fill >= STORE_BYTES) begin
      shadow_open = 1'b0;
      return;
    end
    shadow_store[shadow_fill] = b;
    shadow_fill++;
    if (shadow_fill <= LENGTH_POS) return;
    plen = 32'(shadow_store[LENGTH_POS]);
    total = plen + FRAME_OVERHEAD;  // no wrap, 251+ can never complete
    if (shadow_fill < total) return;
    shadow_open = 1'b0;
    if (shadow_store[total-1] != tail_val) return;
    sum = 8'h00;
    for (int k = 0; k < plen; k++) sum += shadow_store[PAYLOAD_START+k];
    if (shadow_store[PAYLOAD_START+plen] != sum) return;
    pb.command = shadow_store[CMD_POS];
    if (plen == 0) begin
      // empty payload still gives one beat, marked last
      pb.payload_length = 6'd0;
      pb.byte_index = 6'd0;
      pb.data = 8'h00;
      pb.last = 1'b1;
      expected_beats.push_back(pb);
      beats_predicted++;
      return;
    end
    for (int k = 0; k < plen; k++) begin
      pb.payload_length = 6'(plen);
      pb.byte_index = 6'(k);
      pb.data = shadow_store[PAYLOAD_START+k];
      pb.last = (k + 1 == plen);
      expected_beats.push_back(pb);
      beats_predicted++;
    end
  endfunction

  // One in beat. Optional idle burst first; valid then holds until accepted.
  // Returns in the accepting step with valid still high, so the caller
  // either sends again or drops valid in that same step.
  task automatic offer_byte(input logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    tx_count++;
    deframe_byte(b);
  endtask

  // Full frame with the current header and tail. fill < 0 gives random
  // payload salted with header bytes, otherwise every payload byte is fill.
  task automatic send_frame(input logic [7:0] cmd, input int unsigned plen,
                            input frame_flaw_t flaw, input int fill);
    logic [7:0] sum;
    logic [7:0] pb;
    logic [7:0] tl;
    sum = 8'h00;
    offer_byte(hdr_val);
    offer_byte(cmd);
    offer_byte(8'(plen));
    for (int k = 0; k < plen; k++) begin
      if (fill >= 0) pb = 8'(fill);
      else if ($urandom_range(0, 7) == 0) pb = hdr_val;
      else pb = 8'($urandom_range(0, 255));
      sum += pb;
      offer_byte(pb);
    end
    if (flaw == FLAW_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
    tl = tail_val;
    if (flaw == FLAW_TAIL) tl ^= 8'(1 << $urandom_range(0, 7));
    offer_byte(sum);
    offer_byte(tl);
  endtask

  // Length that cannot fit: fill the store, then one more byte to abandon it.
  task automatic send_oversized(input logic [7:0] len, input logic [7:0] spill);
    offer_byte(hdr_val);
    offer_byte(8'($urandom_range(0, 255)));
    offer_byte(len);
    repeat (STORE_BYTES - PAYLOAD_START) offer_byte(8'($urandom_range(0, 255)));
    offer_byte(spill);
  endtask

  // Drop valid, wait for every predicted beat, then let the emitter settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Header, tail and one unmapped index, back to back. Only while idle.
  task automatic program_regs(input logic [7:0] hdr, input logic [7:0] tl);
    logic [7:0] idx [3];
    logic [7:0] val [3];
    idx = '{REG_HEADER, REG_TAIL, REG_NONE};
    val = '{hdr, tl, 8'($urandom_range(0, 255))};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
      if (idx[k] == REG_HEADER) hdr_val = val[k];
      else if (idx[k] == REG_TAIL) tail_val = val[k];
    end
    cfg_valid <= 1'b0;
  endtask

  // --- tests ---------------------------------------------------------------

  // reset header/tail; noise is dropped while hunting; normal and empty frame
  task automatic test_reset_defaults();
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(TAIL_RST);
    send_frame(8'h01, 2, FLAW_NONE, -1);
    send_frame(8'h02, 0, FLAW_NONE, -1);
  endtask

  // field extremes, header bytes inside a frame
  task automatic test_payload_extremes();
    send_frame(8'h00, 1, FLAW_NONE, 0);
    send_frame(hdr_val, 2, FLAW_NONE, hdr_val);
  endtask

  // bad tail and bad sum are dropped silently
  task automatic test_broken_frames();
    send_frame(8'h11, 1, FLAW_TAIL, -1);
    send_frame(8'h13, 0, FLAW_SUM, -1);
  endtask

  // overflow at the wrap-prone length 251
  task automatic test_store_overflow();
    // spill byte equals header and must not reopen; the tail of a would-be
    // empty frame after it is plain noise
    send_oversized(8'd251, hdr_val);
    offer_byte(8'h10);
    offer_byte(8'h00);
    offer_byte(8'h00);
    offer_byte(tail_val);
  endtask

  // register extremes, old header ignored afterwards
  task automatic test_register_extremes();
    wait_idle();
    program_regs(8'h00, 8'hFF);
    offer_byte(HEADER_RST);
    send_frame(8'h31, 1, FLAW_NONE, -1);
    wait_idle();
    program_regs(8'hFF, 8'h00);
    send_frame(8'h33, 0, FLAW_NONE, -1);
    wait_idle();
    program_regs(HEADER_RST, TAIL_RST);
  endtask

  // receiver holds off for a long stretch while the longest frame that fits
  // and one more byte come in: the emitter backs up and the in channel stalls
  task automatic test_output_hold();
    wait_idle();
    hold_req = 1'b1;
    wait (hold_on);
    tx_idle_on = 1'b0;
    send_frame(8'hFF, STORE_BYTES - FRAME_OVERHEAD, FLAW_NONE, 255);
    offer_byte(hdr_val ^ 8'hFF);
    tx_idle_on = 1'b1;
    wait_idle();
  endtask

  // sender pauses after the frame until every beat has drained
  task automatic test_paced_frames();
    send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 4), FLAW_NONE, -1);
    wait_idle();
  endtask

  // Mostly well-formed frames with random content, plus broken frames and
  // noise. Last phase runs with no idling on either side.
  task automatic test_random_traffic();
    int start_tx;
    int r;
    int unsigned plen;
    bit quiet;
    frame_flaw_t flaw;
    for (int ph = 0; ph < 2; ph++) begin
      quiet = (ph == 1);
      wait_idle();
      tx_idle_on = !quiet;
      rx_idle_on = !quiet;
      program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      start_tx = tx_count;
      while (tx_count - start_tx < 8) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          offer_byte(8'($urandom_range(0, 255)));
        end else begin
          plen = $urandom_range(0, 5);
          if (r < 75) flaw = FLAW_NONE;
          else if (r < 87) flaw = FLAW_SUM;
          else flaw = FLAW_TAIL;
          send_frame(8'($urandom_range(0, 255)), plen, flaw, -1);
        end
      end
    end
  endtask

  // --- receiver side ---------------------------------------------------------

  // out_ready: runs of ready, random stall bursts, and the long hold on
  // request. Every branch waits at least one edge, so one write per step.
  initial begin : out_ready_ctl
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_on = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // result checker: every accepted out beat against the oldest prediction
  always @(posedge clk) begin
    payload_beat_t exp_beat;
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected out beat: command %0h index %0d data %0h",
               out_command, out_byte_index, out_data);
        errors++;
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_command !== exp_beat.command) begin
          $error("command: expected %0h, got %0h", exp_beat.command, out_command);
          errors++;
        end
        if (out_payload_length !== exp_beat.payload_length) begin
          $error("payload_length: expected %0d, got %0d",
                 exp_beat.payload_length, out_payload_length);
          errors++;
        end
        if (out_byte_index !== exp_beat.byte_index) begin
          $error("byte_index: expected %0d, got %0d", exp_beat.byte_index, out_byte_index);
          errors++;
        end
        if (out_data !== exp_beat.data) begin
          $error("data: expected %0h, got %0h", exp_beat.data, out_data);
          errors++;
        end
        if (out_last !== exp_beat.last) begin
          $error("last: expected %0b, got %0b", exp_beat.last, out_last);
          errors++;
        end
      end
    end
  end

  // --- main sequence -------------------------------------------------------

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= 8'h00;
    cfg_data <= 8'h00;
    shadow_fill = 0;
    shadow_open = 1'b0;
    hdr_val = HEADER_RST;
    tail_val = TAIL_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_payload_extremes();
    test_broken_frames();
    test_store_overflow();
    test_register_extremes();
    test_output_hold();
    test_paced_frames();
    test_random_traffic();

    wait_idle();
    if (errors == 0 && expected_beats.size() == 0 && beats_seen == beats_predicted) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
rtl/core/bfr_pkg.sv
rtl/core/bfr_ram.sv
rtl/core/bfr_rx.sv
rtl/core/bfr_emit.sv
rtl/core/byte_frame_receiver_core.sv
verif/byte_frame_receiver_core_tb.sv
